@@ design/updc_pkg.sv @@
`timescale 1ns / 1ps

package updc_pkg;

  localparam int MAX_PATH_LEN = 4096;
  localparam int POS_W        = 12;
  localparam int POS_LIMIT_I  = (MAX_PATH_LEN - 1 > 4095) ? 4095 : MAX_PATH_LEN - 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

  localparam logic [1:0] ESC_PLAIN   = 2'd0;
  localparam logic [1:0] ESC_HI      = 2'd1;
  localparam logic [1:0] ESC_LO      = 2'd2;
  localparam logic [1:0] ESC_SWALLOW = 2'd3;

  localparam logic [1:0] TRV_NONE  = 2'd0;
  localparam logic [1:0] TRV_SLASH = 2'd1;
  localparam logic [1:0] TRV_DOT   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ESC   = 2'd1;
  localparam logic [1:0] ST_TRAVERSAL = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] DIG_OFS    = 8'd48;
  localparam logic [7:0] ALPHA_OFS  = 8'd87;
  localparam logic [7:0] CASE_BIT   = 8'd32;

  typedef struct packed {
    logic [1:0]       esc_phase;
    logic [3:0]       high_nibble;
    logic [1:0]       trv_match;
    logic [POS_W-1:0] out_pos;
    logic [POS_W-1:0] last_dot_pos;
    logic             dot_seen;
    logic             last_was_dot;
    logic             ended;
    logic [1:0]       err_code;
  } state_t;

  typedef struct packed {
    logic             has_result;
    logic             byte_valid;
    logic [7:0]       decoded_byte;
    logic             done_res;
    logic [1:0]       status;
    logic             ext_found;
    logic [POS_W-1:0] ext_offset;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - DIG_OFS;
    end else begin
      t = (c | CASE_BIT) - ALPHA_OFS;
    end
    return t[3:0];
  endfunction

endpackage

@@ design/updc_step.sv @@
`timescale 1ns / 1ps

module updc_step (
  input  updc_pkg::state_t  cur,
  input  logic [7:0]        path_byte,
  input  logic              is_final,
  output updc_pkg::state_t  nxt,
  output updc_pkg::result_t res
);
  import updc_pkg::*;

  state_t     s;
  logic       have;
  logic       emit;
  logic [7:0] val;

  always_comb begin
    s    = cur;
    have = 1'b0;
    emit = 1'b0;
    val  = 8'd0;

    unique case (cur.esc_phase)
      ESC_PLAIN: begin
        if (path_byte == 8'd0) begin
          s.esc_phase = ESC_SWALLOW;
        end else if (path_byte == CH_PERCENT) begin
          s.esc_phase = ESC_HI;
        end else begin
          val  = (path_byte == CH_PLUS) ? CH_SPACE : path_byte;
          have = 1'b1;
        end
      end
      ESC_HI: begin
        if (is_hex(path_byte)) begin
          s.high_nibble = hex_val(path_byte);
          s.esc_phase   = ESC_LO;
        end else begin
          s.err_code  = ST_BAD_ESC;
          s.esc_phase = ESC_SWALLOW;
        end
      end
      ESC_LO: begin
        if (is_hex(path_byte)) begin
          val         = {cur.high_nibble, hex_val(path_byte)};
          have        = 1'b1;
          s.esc_phase = ESC_PLAIN;
        end else begin
          s.err_code  = ST_BAD_ESC;
          s.esc_phase = ESC_SWALLOW;
        end
      end
      default: begin
      end
    endcase

    if (have) begin
      if (val == 8'd0) begin
        s.ended = 1'b1;
      end else if (!s.ended) begin
        emit = 1'b1;
        if (val == CH_DOT) begin
          s.last_dot_pos = s.out_pos;
          s.dot_seen     = 1'b1;
          s.last_was_dot = 1'b1;
        end else begin
          s.last_was_dot = 1'b0;
        end
        if (val == CH_SLASH) begin
          s.trv_match = TRV_SLASH;
        end else if (val == CH_DOT && s.trv_match == TRV_SLASH) begin
          s.trv_match = TRV_DOT;
        end else if (val == CH_DOT && s.trv_match == TRV_DOT) begin
          if (s.err_code == ST_OK) s.err_code = ST_TRAVERSAL;
          s.trv_match = TRV_NONE;
        end else begin
          s.trv_match = TRV_NONE;
        end
        if (s.out_pos < POS_LIMIT) s.out_pos = s.out_pos + POS_W'(1);
      end
    end

    if (is_final && (s.esc_phase == ESC_HI || s.esc_phase == ESC_LO)) begin
      s.err_code = ST_BAD_ESC;
    end

    res.has_result   = emit || is_final;
    res.byte_valid   = emit;
    res.decoded_byte = emit ? val : 8'd0;
    res.done_res     = is_final;
    res.status       = is_final ? s.err_code : ST_OK;
    res.ext_found    = is_final && s.dot_seen && !s.last_was_dot;
    res.ext_offset   = (is_final && s.dot_seen) ? s.last_dot_pos : '0;

    nxt = is_final ? state_t'('0) : s;
  end

endmodule

@@ design/url_path_decode_check.sv @@
`timescale 1ns / 1ps

// URL path decoder and checker.
// Input channel (in_valid/in_ready) takes one raw path byte per item, with
// in_is_final marking the last byte. '+' decodes to space, %XX to a byte.
// Output channel (out_valid/out_ready) gives a result item whenever a byte
// is emitted or the final byte arrives; other input items give no result.
// The final result carries status (ok, bad escape, "/.." found), the
// extension flag and the decoded offset of the last dot; state then clears
// for the next path.
// out_valid rises in the cycle after an item with a result is accepted.
// Throughput: one byte per cycle while in_ready is high, set by the single
// decode step between the input handshake and the output register.
// Reset (rst_n low, synchronous) clears the decode state and drops out_valid.
// When the receiver stalls, the held result stays in the output register and
// in_ready drops until it is taken; a new item is accepted in the same cycle
// the held one leaves.

module url_path_decode_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_path_byte,
  input  logic                       in_is_final,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_byte_valid,
  output logic [7:0]                 out_decoded_byte,
  output logic                       out_done_res,
  output logic [1:0]                 out_status,
  output logic                       out_ext_found,
  output logic [updc_pkg::POS_W-1:0] out_ext_offset
);
  import updc_pkg::*;

  state_t  state_r, state_nxt;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  updc_step u_step (
    .cur       (state_r),
    .path_byte (in_path_byte),
    .is_final  (in_is_final),
    .nxt       (state_nxt),
    .res       (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && res.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.has_result) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_decoded_byte = res_r.decoded_byte;
  assign out_done_res     = res_r.done_res;
  assign out_status       = res_r.status;
  assign out_ext_found    = res_r.ext_found;
  assign out_ext_offset   = res_r.ext_offset;

endmodule
